### sv/hpc_pkg.sv
package hpc_pkg;

    localparam int ANGLE_FRAC_BITS  = 22;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int LAT_W     = 30;
    localparam int LON_W     = 31;
    localparam int RADIUS_W  = 23;
    localparam int LEVEL_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int Q_BITS     = 30;
    localparam int ANG_W      = 33;
    localparam int XY_W       = 34;
    localparam int MAG_W      = 33;
    localparam int DEG_W      = 30;
    localparam int D2R_W      = 25;
    localparam int D2R_PROD_W = DEG_W + D2R_W;
    localparam int ROOT_W     = 31;
    localparam int SQ_V_W     = 61;
    localparam int SQ_R_W     = 63;
    localparam int SQRT_STEPS = 32;
    localparam int EARTH_W    = 13;
    localparam int DIST_PROD_W = ROOT_W + EARTH_W;
    localparam int DIST_SHIFT = 21;

    localparam longint FULL_TURN    = longint'(360) << ANGLE_FRAC_BITS;
    localparam longint HALF_TURN    = longint'(180) << ANGLE_FRAC_BITS;
    localparam longint QUARTER_TURN = longint'(90) << ANGLE_FRAC_BITS;

    localparam logic [D2R_W-1:0]    DEG_TO_RAD_Q30  = D2R_W'(18740330);
    localparam logic [Q_BITS-1:0]   CORDIC_INV_GAIN = Q_BITS'(652032874);
    localparam logic [EARTH_W-1:0]  EARTH_RADIUS_KM = EARTH_W'(6371);
    localparam logic [RADIUS_W-1:0] DIST_MAX        = RADIUS_W'(5242879);

    localparam logic [30:0] ATAN_TAB [32] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
        31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
        31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
        31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT = 2'd2;

    localparam logic [LEVEL_W-1:0] LVL_OUT    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_ALARM  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_DETECT = 2'd3;

    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic [DEG_W-1:0]        t_deg;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

endpackage

### sv/hpc_pos_if.sv
interface hpc_pos_if;
    import hpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LON_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LON_W-1:0] second_longitude;

    modport source (
        output valid, first_latitude, first_longitude, second_latitude, second_longitude,
        input  ready
    );
    modport sink (
        input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
        output ready
    );
endinterface

### sv/hpc_dist_if.sv
interface hpc_dist_if;
    import hpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [RADIUS_W-1:0] distance;
    logic [LEVEL_W-1:0]  level;

    modport source (
        output valid, distance, level,
        input  ready
    );
    modport sink (
        input  valid, distance, level,
        output ready
    );
endinterface

### sv/haversine_proximity_classifier.sv
// Great-circle distance and proximity level for a pair of positions.
// Each transaction on i_pos carries two latitude/longitude points in degrees
// scaled by 2^22. Each transaction on o_dist returns the distance in units of
// 1/256 km, saturated at 5242879, and a level: 1 alarm, 2 warning, 3 detection
// or 0 outside. The three radii are written through the i_cfg_* port, by the
// user only while no transaction is in flight; the block does not enforce it.
// The datapath is one pipeline of 42 + 2 * CORDIC_STEPS register stages. A new
// transaction is accepted every cycle while the output is not stalled. The
// depth comes mostly from the rotation CORDIC, the 32-stage square root and
// the vectoring CORDIC.
// The whole pipeline advances together: when the output register holds a
// result that the receiver does not take, every stage holds and i_pos.ready
// falls until the result is taken. Nothing is dropped or repeated.
// A synchronous reset empties the pipeline and clears all radii to zero, so
// after reset only a distance of zero gives level 1.
module haversine_proximity_classifier #(
    parameter int CORDIC_STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hpc_pos_if.sink                          i_pos,
    hpc_dist_if.source                       o_dist,
    input  logic                             i_cfg_we,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hpc_pkg::RADIUS_W-1:0]     i_cfg_data
);
    import hpc_pkg::*;

    localparam int SUM_W = MAG_W + 2;
    localparam logic signed [SUM_W-1:0] L_ONE = SUM_W'(longint'(1) << Q_BITS);
    localparam logic [ROOT_W-1:0] L_ONE_R = ROOT_W'(longint'(1) << Q_BITS);
    localparam logic [DIST_PROD_W:0] L_RND = (DIST_PROD_W + 1)'(1) << (DIST_SHIFT - 1);

    logic en;
    t_ctl ctl_front, ctl_rot, ctl_sqrt, ctl_vec;

    logic front_valid, neg1, neg2;
    t_ang zlat, zlon, zc1, zc2;
    logic rot_valid, tag1, tag2;
    t_xy  xs1, ys1, xs2, ys2, xc1, yc1, xc2, yc2;

    logic [MAG_W-1:0]   w_ms1, w_ms2, w_mc1, w_mc2;
    logic [2*MAG_W-1:0] w_sq1, w_sq2, w_cc, w_p3;
    logic signed [SUM_W-1:0] w_t1, w_t3, w_sum;

    logic r_m1_v, r_m2_v, r_m3_v;
    logic [MAG_W-1:0] r_p1, r_p2, r_ccm, r_p1b, r_p3m;
    logic r_ccn, r_p3n;
    logic [ROOT_W-1:0] r_a;

    logic sqa_valid;
    logic [ROOT_W-1:0] root_a, root_b;
    logic vec_valid;
    t_ang vec_z;

    logic [ROOT_W-1:0] w_zpos;
    logic [DIST_PROD_W:0] w_rnd;
    logic [RADIUS_W:0] w_dq;
    logic r_b1_v, r_b2_v, r_out_v;
    logic [DIST_PROD_W-1:0] r_prod;
    logic [RADIUS_W-1:0] r_dist, r_out_dist;
    logic [LEVEL_W-1:0] r_out_level;
    logic [RADIUS_W-1:0] r_alarm, r_warn, r_detect;

    assign en          = !r_out_v || o_dist.ready;
    assign i_pos.ready = en;

    assign ctl_front = '{en: en, valid: i_pos.valid};
    assign ctl_rot   = '{en: en, valid: front_valid};
    assign ctl_sqrt  = '{en: en, valid: r_m3_v};
    assign ctl_vec   = '{en: en, valid: sqa_valid};

    hpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_front),
        .i_lat1  (i_pos.first_latitude),
        .i_lon1  (i_pos.first_longitude),
        .i_lat2  (i_pos.second_latitude),
        .i_lon2  (i_pos.second_longitude),
        .o_valid (front_valid),
        .o_zlat  (zlat),
        .o_zlon  (zlon),
        .o_zc1   (zc1),
        .o_zc2   (zc2),
        .o_neg1  (neg1),
        .o_neg2  (neg2)
    );

    hpc_rot #(.STEPS(CORDIC_STEPS)) u_rot_s1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_rot), .i_z(zlat), .i_tag(1'b0),
        .o_valid(rot_valid), .o_tag(), .o_x(xs1), .o_y(ys1)
    );
    hpc_rot #(.STEPS(CORDIC_STEPS)) u_rot_s2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_rot), .i_z(zlon), .i_tag(1'b0),
        .o_valid(), .o_tag(), .o_x(xs2), .o_y(ys2)
    );
    hpc_rot #(.STEPS(CORDIC_STEPS)) u_rot_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_rot), .i_z(zc1), .i_tag(neg1),
        .o_valid(), .o_tag(tag1), .o_x(xc1), .o_y(yc1)
    );
    hpc_rot #(.STEPS(CORDIC_STEPS)) u_rot_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_rot), .i_z(zc2), .i_tag(neg2),
        .o_valid(), .o_tag(tag2), .o_x(xc2), .o_y(yc2)
    );

    // Products are taken on magnitudes; the sines are squared, so their signs
    // drop out, while the sign of the cosine product is carried on its own.
    assign w_ms1 = MAG_W'((ys1 < 0) ? -ys1 : ys1);
    assign w_ms2 = MAG_W'((ys2 < 0) ? -ys2 : ys2);
    assign w_mc1 = MAG_W'((xc1 < 0) ? -xc1 : xc1);
    assign w_mc2 = MAG_W'((xc2 < 0) ? -xc2 : xc2);
    assign w_sq1 = (2 * MAG_W)'(w_ms1) * (2 * MAG_W)'(w_ms1);
    assign w_sq2 = (2 * MAG_W)'(w_ms2) * (2 * MAG_W)'(w_ms2);
    assign w_cc  = (2 * MAG_W)'(w_mc1) * (2 * MAG_W)'(w_mc2);
    assign w_p3  = (2 * MAG_W)'(r_ccm) * (2 * MAG_W)'(r_p2);

    assign w_t1  = SUM_W'(r_p1b);
    assign w_t3  = r_p3n ? -SUM_W'(r_p3m) : SUM_W'(r_p3m);
    assign w_sum = w_t1 + w_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= rot_valid;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1  <= w_sq1[Q_BITS +: MAG_W];
            r_p2  <= w_sq2[Q_BITS +: MAG_W];
            r_ccm <= w_cc[Q_BITS +: MAG_W];
            r_ccn <= (xc1 < 0) ^ tag1 ^ (xc2 < 0) ^ tag2;

            r_p1b <= r_p1;
            r_p3m <= w_p3[Q_BITS +: MAG_W];
            r_p3n <= r_ccn;

            if (w_sum < 0) begin
                r_a <= '0;
            end else if (w_sum > L_ONE) begin
                r_a <= L_ONE_R;
            end else begin
                r_a <= ROOT_W'(w_sum);
            end
        end
    end

    hpc_sqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sqrt),
        .i_v     ({r_a, Q_BITS'(0)}),
        .o_valid (sqa_valid),
        .o_root  (root_a)
    );

    hpc_sqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sqrt),
        .i_v     ({L_ONE_R - r_a, Q_BITS'(0)}),
        .o_valid (),
        .o_root  (root_b)
    );

    hpc_vec #(.STEPS(CORDIC_STEPS)) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_vec),
        .i_x     (root_b),
        .i_y     (root_a),
        .o_valid (vec_valid),
        .o_z     (vec_z)
    );

    assign w_zpos = (vec_z < 0) ? '0 : ROOT_W'(vec_z);
    assign w_rnd  = (DIST_PROD_W + 1)'(r_prod) + L_RND;
    assign w_dq   = w_rnd[DIST_SHIFT +: RADIUS_W + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_b1_v  <= vec_valid;
            r_b2_v  <= r_b1_v;
            r_out_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod     <= DIST_PROD_W'(w_zpos) * DIST_PROD_W'(EARTH_RADIUS_KM);
            r_dist     <= (w_dq > (RADIUS_W + 1)'(DIST_MAX)) ? DIST_MAX : RADIUS_W'(w_dq);
            r_out_dist <= r_dist;
            if (r_dist <= r_alarm) begin
                r_out_level <= LVL_ALARM;
            end else if (r_dist <= r_warn) begin
                r_out_level <= LVL_WARN;
            end else if (r_dist <= r_detect) begin
                r_out_level <= LVL_DETECT;
            end else begin
                r_out_level <= LVL_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm  <= '0;
            r_warn   <= '0;
            r_detect <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALARM:  r_alarm  <= i_cfg_data;
                CFG_WARN:   r_warn   <= i_cfg_data;
                CFG_DETECT: r_detect <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_dist.valid    = r_out_v;
    assign o_dist.distance = r_out_dist;
    assign o_dist.level    = r_out_level;

`ifndef SYNTHESIS
    a_dist_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.valid |-> o_dist.distance <= DIST_MAX)
        else $error("distance above saturation limit");

    a_zero_is_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dist.valid && o_dist.distance == '0) |-> o_dist.level == LVL_ALARM)
        else $error("zero distance not classified as alarm");
`endif

endmodule

### sv/hpc_front.sv
module hpc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hpc_pkg::t_ctl                    i_ctl,
    input  logic signed [hpc_pkg::LAT_W-1:0] i_lat1,
    input  logic signed [hpc_pkg::LON_W-1:0] i_lon1,
    input  logic signed [hpc_pkg::LAT_W-1:0] i_lat2,
    input  logic signed [hpc_pkg::LON_W-1:0] i_lon2,
    output logic                             o_valid,
    output hpc_pkg::t_ang                    o_zlat,
    output hpc_pkg::t_ang                    o_zlon,
    output hpc_pkg::t_ang                    o_zc1,
    output hpc_pkg::t_ang                    o_zc2,
    output logic                             o_neg1,
    output logic                             o_neg2
);
    import hpc_pkg::*;

    localparam t_ang L_FULL    = ANG_W'(FULL_TURN);
    localparam t_ang L_HALF    = ANG_W'(HALF_TURN);
    localparam t_deg L_HALF_M  = DEG_W'(HALF_TURN);
    localparam t_deg L_QUARTER = DEG_W'(QUARTER_TURN);
    localparam logic [D2R_PROD_W:0] RND_SIN = (D2R_PROD_W + 1)'(1) << ANGLE_FRAC_BITS;
    localparam logic [D2R_PROD_W:0] RND_COS = (D2R_PROD_W + 1)'(1) << (ANGLE_FRAC_BITS - 1);

    function automatic t_deg fold_mag(input t_ang r);
        t_ang m;
        if (r > L_HALF) begin
            m = L_FULL - r;
        end else if (r < -L_HALF) begin
            m = L_FULL + r;
        end else if (r < 0) begin
            m = -r;
        end else begin
            m = r;
        end
        return DEG_W'(m);
    endfunction

    function automatic t_deg abs_lat(input logic signed [LAT_W-1:0] v);
        t_ang e;
        e = ANG_W'(v);
        return (e < 0) ? DEG_W'(-e) : DEG_W'(e);
    endfunction

    t_ang w_dlat;
    t_ang w_dlon_raw;
    t_ang w_dlon;
    logic [D2R_PROD_W:0] w_rs1, w_rs2, w_rc1, w_rc2;

    logic r_v1, r_v2, r_v3, r_v4;
    t_ang r_dlat, r_dlon;
    t_deg r_alat1, r_alat2;
    t_deg r_ms1, r_ms2, r_mc1, r_mc2;
    logic r_n1_2, r_n2_2, r_n1_3, r_n2_3, r_n1_4, r_n2_4;
    logic [D2R_PROD_W-1:0] r_ps1, r_ps2, r_pc1, r_pc2;
    t_ang r_zlat, r_zlon, r_zc1, r_zc2;

    assign w_dlat     = ANG_W'(i_lat2) - ANG_W'(i_lat1);
    assign w_dlon_raw = ANG_W'(i_lon2) - ANG_W'(i_lon1);
    assign w_dlon     = (w_dlon_raw >= L_FULL)  ? w_dlon_raw - L_FULL :
                        (w_dlon_raw <= -L_FULL) ? w_dlon_raw + L_FULL : w_dlon_raw;

    assign w_rs1 = ((D2R_PROD_W + 1)'(r_ps1) + RND_SIN) >> (ANGLE_FRAC_BITS + 1);
    assign w_rs2 = ((D2R_PROD_W + 1)'(r_ps2) + RND_SIN) >> (ANGLE_FRAC_BITS + 1);
    assign w_rc1 = ((D2R_PROD_W + 1)'(r_pc1) + RND_COS) >> ANGLE_FRAC_BITS;
    assign w_rc2 = ((D2R_PROD_W + 1)'(r_pc2) + RND_COS) >> ANGLE_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_dlat  <= w_dlat;
            r_dlon  <= w_dlon;
            r_alat1 <= abs_lat(i_lat1);
            r_alat2 <= abs_lat(i_lat2);

            r_ms1  <= fold_mag(r_dlat);
            r_ms2  <= fold_mag(r_dlon);
            r_mc1  <= (r_alat1 > L_QUARTER) ? L_HALF_M - r_alat1 : r_alat1;
            r_mc2  <= (r_alat2 > L_QUARTER) ? L_HALF_M - r_alat2 : r_alat2;
            r_n1_2 <= r_alat1 > L_QUARTER;
            r_n2_2 <= r_alat2 > L_QUARTER;

            r_ps1  <= D2R_PROD_W'(r_ms1) * D2R_PROD_W'(DEG_TO_RAD_Q30);
            r_ps2  <= D2R_PROD_W'(r_ms2) * D2R_PROD_W'(DEG_TO_RAD_Q30);
            r_pc1  <= D2R_PROD_W'(r_mc1) * D2R_PROD_W'(DEG_TO_RAD_Q30);
            r_pc2  <= D2R_PROD_W'(r_mc2) * D2R_PROD_W'(DEG_TO_RAD_Q30);
            r_n1_3 <= r_n1_2;
            r_n2_3 <= r_n2_2;

            r_zlat <= ANG_W'(w_rs1);
            r_zlon <= ANG_W'(w_rs2);
            r_zc1  <= ANG_W'(w_rc1);
            r_zc2  <= ANG_W'(w_rc2);
            r_n1_4 <= r_n1_3;
            r_n2_4 <= r_n2_3;
        end
    end

    assign o_valid = r_v4;
    assign o_zlat  = r_zlat;
    assign o_zlon  = r_zlon;
    assign o_zc1   = r_zc1;
    assign o_zc2   = r_zc2;
    assign o_neg1  = r_n1_4;
    assign o_neg2  = r_n2_4;

endmodule

### sv/hpc_rot.sv
module hpc_rot #(
    parameter int STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpc_pkg::t_ctl i_ctl,
    input  hpc_pkg::t_ang i_z,
    input  logic          i_tag,
    output logic          o_valid,
    output logic          o_tag,
    output hpc_pkg::t_xy  o_x,
    output hpc_pkg::t_xy  o_y
);
    import hpc_pkg::*;

    logic r_v [STEPS];
    logic r_t [STEPS];
    t_xy  r_x [STEPS];
    t_xy  r_y [STEPS];
    t_ang r_z [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic w_vp, w_tp;
        t_xy  w_xp, w_yp;
        t_ang w_zp;
        t_ang w_at;

        if (i == 0) begin : g_first
            assign w_vp = i_ctl.valid;
            assign w_tp = i_tag;
            assign w_xp = XY_W'(CORDIC_INV_GAIN);
            assign w_yp = '0;
            assign w_zp = i_z;
        end else begin : g_next
            assign w_vp = r_v[i-1];
            assign w_tp = r_t[i-1];
            assign w_xp = r_x[i-1];
            assign w_yp = r_y[i-1];
            assign w_zp = r_z[i-1];
        end

        assign w_at = $signed({2'b00, ATAN_TAB[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[i] <= w_vp;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_t[i] <= w_tp;
                if (w_zp >= 0) begin
                    r_x[i] <= w_xp - (w_yp >>> i);
                    r_y[i] <= w_yp + (w_xp >>> i);
                    r_z[i] <= w_zp - w_at;
                end else begin
                    r_x[i] <= w_xp + (w_yp >>> i);
                    r_y[i] <= w_yp - (w_xp >>> i);
                    r_z[i] <= w_zp + w_at;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_tag   = r_t[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];

endmodule

### sv/hpc_sqrt.sv
module hpc_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hpc_pkg::t_ctl                    i_ctl,
    input  logic [hpc_pkg::SQ_V_W-1:0]       i_v,
    output logic                             o_valid,
    output logic [hpc_pkg::ROOT_W-1:0]       o_root
);
    import hpc_pkg::*;

    logic              r_ok [SQRT_STEPS];
    logic [SQ_V_W-1:0] r_v  [SQRT_STEPS];
    logic [SQ_R_W-1:0] r_r  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQ_R_W-1:0] BIT = SQ_R_W'(1) << (SQ_R_W - 1 - 2 * k);
        logic              w_okp;
        logic [SQ_V_W-1:0] w_vp;
        logic [SQ_R_W-1:0] w_rp;
        logic [SQ_R_W-1:0] w_try;

        if (k == 0) begin : g_first
            assign w_okp = i_ctl.valid;
            assign w_vp  = i_v;
            assign w_rp  = '0;
        end else begin : g_next
            assign w_okp = r_ok[k-1];
            assign w_vp  = r_v[k-1];
            assign w_rp  = r_r[k-1];
        end

        assign w_try = w_rp + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ok[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_ok[k] <= w_okp;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (SQ_R_W'(w_vp) >= w_try) begin
                    r_v[k] <= w_vp - SQ_V_W'(w_try);
                    r_r[k] <= (w_rp >> 1) + BIT;
                end else begin
                    r_v[k] <= w_vp;
                    r_r[k] <= w_rp >> 1;
                end
            end
        end
    end

    assign o_valid = r_ok[SQRT_STEPS-1];
    assign o_root  = ROOT_W'(r_r[SQRT_STEPS-1]);

endmodule

### sv/hpc_vec.sv
module hpc_vec #(
    parameter int STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hpc_pkg::t_ctl               i_ctl,
    input  logic [hpc_pkg::ROOT_W-1:0]  i_x,
    input  logic [hpc_pkg::ROOT_W-1:0]  i_y,
    output logic                        o_valid,
    output hpc_pkg::t_ang               o_z
);
    import hpc_pkg::*;

    logic r_v [STEPS];
    t_xy  r_x [STEPS];
    t_xy  r_y [STEPS];
    t_ang r_z [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic w_vp;
        t_xy  w_xp, w_yp;
        t_ang w_zp;
        t_ang w_at;

        if (i == 0) begin : g_first
            assign w_vp = i_ctl.valid;
            assign w_xp = XY_W'(i_x);
            assign w_yp = XY_W'(i_y);
            assign w_zp = '0;
        end else begin : g_next
            assign w_vp = r_v[i-1];
            assign w_xp = r_x[i-1];
            assign w_yp = r_y[i-1];
            assign w_zp = r_z[i-1];
        end

        assign w_at = $signed({2'b00, ATAN_TAB[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[i] <= w_vp;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (w_yp >= 0) begin
                    r_x[i] <= w_xp + (w_yp >>> i);
                    r_y[i] <= w_yp - (w_xp >>> i);
                    r_z[i] <= w_zp + w_at;
                end else begin
                    r_x[i] <= w_xp - (w_yp >>> i);
                    r_y[i] <= w_yp + (w_xp >>> i);
                    r_z[i] <= w_zp - w_at;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_z     = r_z[STEPS-1];

endmodule

### sim/tb_haversine_proximity_classifier.sv
module tb_haversine_proximity_classifier;
    import hpc_pkg::*;

    localparam int  PIPE_DEPTH  = 42 + 2 * CORDIC_STEPS_DEF;
    localparam int  STALL_LIMIT = 3000;
    localparam int  LONG_HOLD   = 400;
    localparam longint LAT_SPAN = 377487360;
    localparam longint LON_SPAN = 754974720;

    typedef struct {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
    } t_pos_pair;

    typedef struct {
        logic [RADIUS_W-1:0] distance;
        logic [LEVEL_W-1:0]  level;
    } t_proximity;

    class proximity_scoreboard;
        logic [RADIUS_W-1:0] alarm_r, warn_r, detect_r;
        t_proximity          pending[$];
        int                  errors;
        int                  checked;
        int                  levels_seen[4];

        function new();
            alarm_r = '0;
            warn_r = '0;
            detect_r = '0;
            errors = 0;
            checked = 0;
        endfunction

        function longint wrap_deg(longint v);
            longint full_turn;
            longint r;
            full_turn = longint'(360) << ANGLE_FRAC_BITS;
            r = v % full_turn;
            if (r > full_turn / 2) begin
                r = r - full_turn;
            end else if (r < -(full_turn / 2)) begin
                r = r + full_turn;
            end
            return r;
        endfunction

        function longint to_radians(longint mag, int extra);
            int     sh;
            longint p;
            sh = ANGLE_FRAC_BITS + extra;
            p = mag * longint'(18740330);
            return (p + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint atan_step(int i);
            return (i < 32) ? longint'(ATAN_TAB[i]) : 0;
        endfunction

        function void rotate(longint z, output longint c, output longint s);
            longint x, y, dx, dy;
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atan_step(i);
                end else begin
                    x = x + dx; y = y - dy; z = z + atan_step(i);
                end
            end
            c = x;
            s = y;
        endfunction

        function longint vector_angle(longint x, longint y);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy; z = z + atan_step(i);
                end else begin
                    x = x - dx; y = y + dy; z = z - atan_step(i);
                end
            end
            return z;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            for (int k = 0; k < 32; k++) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint q_mul(longint a, longint b);
            longint unsigned ma, mb;
            longint r;
            ma = (a < 0) ? longint'(-a) : a;
            mb = (b < 0) ? longint'(-b) : b;
            r = longint'((ma * mb) >> Q_BITS);
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function longint half_sine(longint d);
            longint r, c, s;
            r = wrap_deg(d);
            if (r < 0) r = -r;
            rotate(to_radians(r, 1), c, s);
            return s;
        endfunction

        function longint lat_cosine(longint lat);
            longint r, c, s;
            bit     flip;
            r = wrap_deg(lat);
            flip = 0;
            if (r < 0) r = -r;
            if (r > (longint'(90) << ANGLE_FRAC_BITS)) begin
                r = (longint'(180) << ANGLE_FRAC_BITS) - r;
                flip = 1;
            end
            rotate(to_radians(r, 0), c, s);
            return flip ? -c : c;
        endfunction

        function t_proximity classify(t_pos_pair p);
            longint        s1, s2, cc, a, z;
            longint unsigned span_q;
            t_proximity    res;
            s1 = half_sine(longint'(p.lat_b) - longint'(p.lat_a));
            s2 = half_sine(longint'(p.lon_b) - longint'(p.lon_a));
            cc = q_mul(lat_cosine(p.lat_a), lat_cosine(p.lat_b));
            a = q_mul(s1, s1) + q_mul(cc, q_mul(s2, s2));
            if (a < 0) a = 0;
            if (a > (longint'(1) << Q_BITS)) a = longint'(1) << Q_BITS;
            z = vector_angle(
                longint'(int_root(longint'((longint'(1) << Q_BITS) - a) << Q_BITS)),
                longint'(int_root(longint'(a) << Q_BITS)));
            if (z < 0) z = 0;
            span_q = (longint'(z) * 6371 + (64'd1 << 20)) >> 21;
            if (span_q > 5242879) span_q = 5242879;
            res.distance = span_q[RADIUS_W-1:0];
            if (span_q <= alarm_r) res.level = LVL_ALARM;
            else if (span_q <= warn_r) res.level = LVL_WARN;
            else if (span_q <= detect_r) res.level = LVL_DETECT;
            else res.level = LVL_OUT;
            return res;
        endfunction

        function void note_pair(t_pos_pair p);
            pending.push_back(classify(p));
        endfunction

        function void check_result(logic [RADIUS_W-1:0] distance, logic [LEVEL_W-1:0] level);
            t_proximity exp_res;
            if (pending.size() == 0) begin
                $error("unexpected result: distance %0d level %0d", distance, level);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            checked++;
            levels_seen[level]++;
            if (distance !== exp_res.distance) begin
                $error("distance: expected %0d, actual %0d", exp_res.distance, distance);
                errors++;
            end
            if (level !== exp_res.level) begin
                $error("level: expected %0d, actual %0d", exp_res.level, level);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RADIUS_W-1:0]  i_cfg_data;

    hpc_pos_if  pos_if ();
    hpc_dist_if dist_if ();

    haversine_proximity_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pos      (pos_if.sink),
        .o_dist     (dist_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    proximity_scoreboard sb = new();
    bit hold_request;
    bit no_idle;
    int stall_cycles;
    int pairs_sent;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pos_if.valid = 0;
        pos_if.first_latitude = '0;
        pos_if.first_longitude = '0;
        pos_if.second_latitude = '0;
        pos_if.second_longitude = '0;
        dist_if.ready = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pos_if.valid && pos_if.ready) begin
                t_pos_pair p;
                p.lat_a = pos_if.first_latitude;
                p.lon_a = pos_if.first_longitude;
                p.lat_b = pos_if.second_latitude;
                p.lon_b = pos_if.second_longitude;
                sb.note_pair(p);
            end
            if (dist_if.valid && dist_if.ready) begin
                sb.check_result(dist_if.distance, dist_if.level);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pos_if.valid && pos_if.ready) || (dist_if.valid && dist_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                dist_if.ready <= 0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (stall_left > 0 && !no_idle) begin
                stall_left--;
                dist_if.ready <= 0;
            end else begin
                dist_if.ready <= 1;
                if (!no_idle && $urandom_range(0, 7) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    task automatic send_pair(longint la, longint oa, longint lb, longint ob);
        int gap;
        pos_if.valid <= 1;
        pos_if.first_latitude <= LAT_W'(la);
        pos_if.first_longitude <= LON_W'(oa);
        pos_if.second_latitude <= LAT_W'(lb);
        pos_if.second_longitude <= LON_W'(ob);
        do @(posedge i_clk); while (!pos_if.ready);
        pairs_sent++;
        gap = 0;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            pos_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (pos_if.valid) begin
            pos_if.valid <= 0;
        end
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_ALARM:  sb.alarm_r = value;
            CFG_WARN:   sb.warn_r = value;
            CFG_DETECT: sb.detect_r = value;
            default: ;
        endcase
    endtask

    task automatic set_radii(logic [RADIUS_W-1:0] a, logic [RADIUS_W-1:0] w,
                             logic [RADIUS_W-1:0] d);
        write_radius(CFG_ALARM, a);
        write_radius(CFG_WARN, w);
        write_radius(CFG_DETECT, d);
    endtask

    function automatic longint any_lat();
        return longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
    endfunction

    function automatic longint any_lon();
        return longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN;
    endfunction

    task automatic random_pair();
        int     kind;
        longint la, oa, lb, ob, reach;
        kind = $urandom_range(0, 9);
        la = any_lat();
        oa = any_lon();
        if (kind < 4) begin
            reach = longint'(1) << $urandom_range(4, 26);
            lb = la + longint'($urandom_range(0, 2 * reach)) - reach;
            ob = oa + longint'($urandom_range(0, 2 * reach)) - reach;
        end else if (kind < 8) begin
            lb = any_lat();
            ob = any_lon();
        end else begin
            la = longint'($urandom());
            oa = longint'($urandom());
            lb = longint'($urandom());
            ob = longint'($urandom());
        end
        send_pair(la, oa, lb, ob);
    endtask

    task automatic random_run(int count);
        for (int n = 0; n < count; n++) begin
            random_pair();
        end
    endtask

    initial begin
        hold_request = 0;
        no_idle = 0;
        pairs_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed pairs against the all-zero radii left by reset.
        send_pair(0, 0, 0, 0);
        send_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
        send_pair(0, 0, 0, LON_SPAN);
        send_pair(0, -LON_SPAN, 0, LON_SPAN);
        send_pair(LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN);
        send_pair(-LAT_SPAN, 123, -LAT_SPAN, -LON_SPAN);
        send_pair(100, 200, 101, 200);
        send_pair(0, 0, 0, 1);
        send_pair(-(longint'(1) << 29), -(longint'(1) << 30), (longint'(1) << 29) - 1,
                  (longint'(1) << 30) - 1);
        send_pair((longint'(1) << 29) - 1, (longint'(1) << 30) - 1,
                  -(longint'(1) << 29), -(longint'(1) << 30));
        send_pair(LAT_SPAN / 2, LON_SPAN / 3, -LAT_SPAN / 2, -LON_SPAN / 3 * 2);
        send_pair(12345678, 87654321, 12345678, 87654321 + LON_SPAN);
        drain();

        set_radii(RADIUS_W'(256), RADIUS_W'(256 * 100), RADIUS_W'(256 * 2000));
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 37699, 0);
        send_pair(0, 0, 3769900, 0);
        send_pair(0, 0, 75398000, 0);
        send_pair(0, 0, LAT_SPAN, 0);
        random_run(120);
        drain();

        set_radii(RADIUS_W'(5242879), RADIUS_W'(5242879), RADIUS_W'(5242879));
        no_idle = 1;
        random_run(80);
        drain();
        no_idle = 0;

        set_radii(RADIUS_W'($urandom_range(0, 2000)), RADIUS_W'($urandom_range(2000, 200000)),
                  RADIUS_W'($urandom_range(200000, 5242879)));
        hold_request = 1;
        random_run(250);
        drain();

        set_radii(RADIUS_W'($urandom_range(0, 5242879)), RADIUS_W'($urandom_range(0, 5242879)),
                  RADIUS_W'($urandom_range(0, 5242879)));
        random_run(150);
        drain();

        set_radii(RADIUS_W'(1000000), RADIUS_W'(1000000), RADIUS_W'(8388607));
        random_run(100);
        drain();

        set_radii('0, '0, '0);
        random_run(150);
        drain();

        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Sent %0d position pairs over seven radius settings; %0d results checked.",
                 pairs_sent, sb.checked);
        $display("Levels seen: outside %0d, alarm %0d, warning %0d, detection %0d.",
                 sb.levels_seen[0], sb.levels_seen[1], sb.levels_seen[2], sb.levels_seen[3]);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### haversine_proximity_classifier.f
sv/hpc_pkg.sv
sv/hpc_pos_if.sv
sv/hpc_dist_if.sv
sv/hpc_front.sv
sv/hpc_rot.sv
sv/hpc_sqrt.sv
sv/hpc_vec.sv
sv/haversine_proximity_classifier.sv
sim/tb_haversine_proximity_classifier.sv
